// ===== sv/mcat_pkg.sv =====
// package for the multi-channel alarm timer
// types, constants and request codes shared by all timer modules
package mcat_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] DUE_OFF = 32'hffff_ffff;
  localparam logic [7:0] TICK_PERIOD_RESET = 8'd16;

  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_TICK_PERIOD = '0;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_ARM        = 3'd1,
    REQ_DISARM     = 3'd2,
    REQ_DISARM_ALL = 3'd3,
    REQ_MARK       = 3'd4,
    REQ_QUERY      = 3'd5
  } req_type_t;

  typedef struct packed {
    logic                    kind;
    logic [NUM_CHANNELS-1:0] fire_mask;
    logic [1:0]              channel;
    logic                    is_due;
    logic [31:0]             ticks;
    logic [31:0]             elapsed;
  } job_t;

endpackage

// ===== sv/mcat_req_if.sv =====
// request channel of the alarm timer
// valid/ready handshake with the request fields, no dependencies
interface mcat_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [1:0]  channel;
  logic [31:0] delay_ticks;
  logic [31:0] reload_ticks;

  modport source (output valid, req_type, channel, delay_ticks, reload_ticks, input ready);
  modport sink (input valid, req_type, channel, delay_ticks, reload_ticks, output ready);
endinterface

// ===== sv/mcat_res_if.sv =====
// result channel of the alarm timer
// valid/ready handshake with the result fields, no dependencies
interface mcat_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  fired_channel;
  logic        is_due;
  logic [31:0] tick_ms;
  logic [31:0] elapsed_ms;
  logic        is_last;

  modport source (output valid, kind, fired_channel, is_due, tick_ms, elapsed_ms, is_last,
                  input ready);
  modport sink (input valid, kind, fired_channel, is_due, tick_ms, elapsed_ms, is_last,
                output ready);
endinterface

// ===== sv/multi_channel_alarm_timer_unit.sv =====
// multi-channel alarm timer, top level: front end, job queue, back end, config port
// a job passes the job queue, then the current and output registers of the back end
// throughput: one request per cycle unless the queue is full; a result per fired channel
// the front end stalls only when the four-entry job queue is full
// reset (rst, synchronous): count, start mark and reloads zero, channels off, period 16
module multi_channel_alarm_timer_unit import mcat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mcat_req_if.sink              req,
  mcat_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0] tick_period;
  logic       q_push;
  job_t       q_push_job;
  logic       q_full;
  logic       q_pop;
  logic       q_head_valid;
  job_t       q_head_job;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TICK_PERIOD) ? {24'd0, tick_period} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_TICK_PERIOD)) begin
      tick_period <= pwdata[7:0];
    end
  end

  mcat_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .full (q_full),
    .push (q_push),
    .job  (q_push_job)
  );

  mcat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  mcat_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tick_period (tick_period),
    .head_valid  (q_head_valid),
    .head_job    (q_head_job),
    .pop         (q_pop),
    .res         (res)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_ack_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_ACK) |-> res.is_last)
    else $error("acknowledgment not marked last");

  a_fired_not_due: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_FIRED) |-> !res.is_due)
    else $error("fired result carries due flag");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("pop from empty queue");

endmodule

// ===== sv/mcat_front.sv =====
// front end: accepts requests, updates counter and channel state, builds jobs
// depends on mcat_pkg and mcat_req_if
module mcat_front import mcat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mcat_req_if.sink   req,
  input  logic       full,
  output logic       push,
  output job_t       job
);

  logic [31:0] tick_count, tick_count_next;
  logic [31:0] elapsed, elapsed_next;
  logic [31:0] due [NUM_CHANNELS];
  logic [31:0] due_next [NUM_CHANNELS];
  logic [31:0] reload [NUM_CHANNELS];
  logic [31:0] reload_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] sel;
  logic [NUM_CHANNELS-1:0] fire;
  logic        accept;
  logic        query_due;

  assign req.ready = !full;
  assign accept = req.valid && req.ready;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sel[i] = (int'(req.channel) == i);
    end
  end

  always_comb begin
    tick_count_next = tick_count;
    elapsed_next = elapsed;
    fire = '0;
    query_due = 1'b0;
    push = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      due_next[i] = due[i];
      reload_next[i] = reload[i];
    end
    if (accept) begin
      case (req_type_t'(req.req_type))
        REQ_TICK: begin
          tick_count_next = tick_count + 32'd1;
          elapsed_next = elapsed + 32'd1;
          // due < count + 1 without the carry chain through the increment
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            fire[i] = (due[i] <= tick_count) && (tick_count != DUE_OFF);
            if (fire[i]) begin
              due_next[i] = (reload[i] != '0) ? tick_count + reload[i] + 32'd1 : DUE_OFF;
            end
          end
          push = |fire;
        end
        REQ_ARM: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (sel[i]) begin
              due_next[i] = tick_count + req.delay_ticks;
              reload_next[i] = req.reload_ticks;
            end
          end
          push = 1'b1;
        end
        REQ_DISARM: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (sel[i]) begin
              due_next[i] = DUE_OFF;
              reload_next[i] = '0;
            end
          end
          push = 1'b1;
        end
        REQ_DISARM_ALL: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            due_next[i] = DUE_OFF;
            reload_next[i] = '0;
          end
          push = 1'b1;
        end
        REQ_MARK: begin
          elapsed_next = '0;
          push = 1'b1;
        end
        REQ_QUERY: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (sel[i] && (tick_count > due[i])) begin
              query_due = 1'b1;
            end
          end
          push = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    job.kind = (req_type_t'(req.req_type) == REQ_TICK) ? KIND_FIRED : KIND_ACK;
    job.fire_mask = fire;
    job.channel = req.channel;
    job.is_due = query_due;
    job.ticks = tick_count_next;
    job.elapsed = elapsed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      elapsed <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        due[i] <= DUE_OFF;
        reload[i] <= '0;
      end
    end else begin
      tick_count <= tick_count_next;
      elapsed <= elapsed_next;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        due[i] <= due_next[i];
        reload[i] <= reload_next[i];
      end
    end
  end

endmodule

// ===== sv/mcat_queue.sv =====
// job queue between front and back end of the alarm timer
// depends on mcat_pkg
module mcat_queue import mcat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + (QPTR_W+1)'(1);
        2'b01: count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/mcat_back.sv =====
// back end: scales times to milliseconds, emits one result per fired channel or per acknowledgment
// depends on mcat_pkg and mcat_res_if
module mcat_back import mcat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] tick_period,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  mcat_res_if.source res
);

  logic                    cur_valid;
  logic                    cur_kind;
  logic [NUM_CHANNELS-1:0] cur_mask;
  logic [1:0]              cur_channel;
  logic                    cur_is_due;
  logic [31:0]             cur_tick_ms;
  logic [31:0]             cur_elapsed_ms;

  logic                    out_valid;
  logic                    out_kind;
  logic [1:0]              out_channel;
  logic                    out_is_due;
  logic [31:0]             out_tick_ms;
  logic [31:0]             out_elapsed_ms;
  logic                    out_last;

  logic [31:0]             tick_prod;
  logic [31:0]             elapsed_prod;
  logic [CH_W-1:0]         low_idx;
  logic [NUM_CHANNELS-1:0] mask_rest;
  logic                    cur_last;
  logic                    emit;

  assign tick_prod = head_job.ticks * {24'd0, tick_period};
  assign elapsed_prod = head_job.elapsed * {24'd0, tick_period};

  // lowest pending channel goes first
  always_comb begin
    low_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        low_idx = CH_W'(i);
      end
    end
  end

  assign mask_rest = cur_mask & (cur_mask - NUM_CHANNELS'(1));
  assign cur_last = (cur_kind == KIND_ACK) || (mask_rest == '0);
  assign emit = cur_valid && (!out_valid || res.ready);
  assign pop = head_valid && (!cur_valid || (emit && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (emit && cur_last) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind <= head_job.kind;
      cur_mask <= head_job.fire_mask;
      cur_channel <= head_job.channel;
      cur_is_due <= head_job.is_due;
      cur_tick_ms <= tick_prod;
      cur_elapsed_ms <= elapsed_prod;
    end else if (emit) begin
      cur_mask <= mask_rest;
    end
    if (emit) begin
      out_kind <= cur_kind;
      out_channel <= (cur_kind == KIND_ACK) ? cur_channel : 2'(low_idx);
      out_is_due <= cur_is_due;
      out_tick_ms <= cur_tick_ms;
      out_elapsed_ms <= cur_elapsed_ms;
      out_last <= cur_last;
    end
  end

  assign res.valid = out_valid;
  assign res.kind = out_kind;
  assign res.fired_channel = out_channel;
  assign res.is_due = out_is_due;
  assign res.tick_ms = out_tick_ms;
  assign res.elapsed_ms = out_elapsed_ms;
  assign res.is_last = out_last;

endmodule

// ===== bench/alarm_timer_check.sv =====
// checker for the multi-channel alarm timer: predicts and compares every result
// watches the request, result and register ports; depends on mcat_pkg and the channel interfaces
module alarm_timer_check import mcat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mcat_req_if         req,
  mcat_res_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding,
  output int          requests_seen,
  output int          alarms_seen,
  output int          answers_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [1:0]  chan;
    logic        due;
    logic [31:0] tick_ms;
    logic [31:0] elapsed_ms;
    logic        last;
  } timer_result_t;

  timer_result_t timer_results_q[$];

  logic [7:0]  period_ms;
  logic [31:0] tick_count;
  logic [31:0] start_mark;
  logic [31:0] due_time [NUM_CHANNELS];
  logic [31:0] reload_period [NUM_CHANNELS];

  initial begin
    errors = 0;
    outstanding = 0;
    requests_seen = 0;
    alarms_seen = 0;
    answers_seen = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] to_ms(logic [31:0] ticks);
    return ticks * {24'h0, period_ms};
  endfunction

  task automatic push_result(logic kind, logic [1:0] chan, logic due);
    timer_result_t r;
    r.kind = kind;
    r.chan = chan;
    r.due = due;
    r.tick_ms = to_ms(tick_count);
    r.elapsed_ms = to_ms(tick_count - start_mark);
    r.last = 1'b0;
    timer_results_q.insert(timer_results_q.size(), r);
  endtask

  task automatic advance_timer(logic [2:0] code, logic [1:0] chan, logic [31:0] delay,
                               logic [31:0] reload);
    int first;
    first = timer_results_q.size();
    case (code)
      REQ_TICK: begin
        tick_count = tick_count + 32'd1;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (due_time[i] < tick_count) begin
            due_time[i] = (reload_period[i] != 0) ? tick_count + reload_period[i] : DUE_OFF;
            push_result(KIND_FIRED, 2'(i), 1'b0);
          end
        end
      end
      REQ_ARM: begin
        due_time[chan] = tick_count + delay;
        reload_period[chan] = reload;
        push_result(KIND_ACK, chan, 1'b0);
      end
      REQ_DISARM: begin
        due_time[chan] = DUE_OFF;
        reload_period[chan] = '0;
        push_result(KIND_ACK, chan, 1'b0);
      end
      REQ_DISARM_ALL: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          due_time[i] = DUE_OFF;
          reload_period[i] = '0;
        end
        push_result(KIND_ACK, chan, 1'b0);
      end
      REQ_MARK: begin
        start_mark = tick_count;
        push_result(KIND_ACK, chan, 1'b0);
      end
      REQ_QUERY: push_result(KIND_ACK, chan, tick_count > due_time[chan]);
      default: ;
    endcase
    if (timer_results_q.size() > first)
      timer_results_q[timer_results_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_result();
    timer_result_t want;
    if (timer_results_q.size() == 0) begin
      report_mismatch("result with nothing expected", {30'h0, res.fired_channel}, '0);
    end else begin
      want = timer_results_q.pop_front();
      if (res.kind !== want.kind)
        report_mismatch("kind", 32'(res.kind), 32'(want.kind));
      if (res.fired_channel !== want.chan)
        report_mismatch("fired_channel", 32'(res.fired_channel), 32'(want.chan));
      if (res.is_due !== want.due)
        report_mismatch("is_due", 32'(res.is_due), 32'(want.due));
      if (res.tick_ms !== want.tick_ms) report_mismatch("tick_ms", res.tick_ms, want.tick_ms);
      if (res.elapsed_ms !== want.elapsed_ms)
        report_mismatch("elapsed_ms", res.elapsed_ms, want.elapsed_ms);
      if (res.is_last !== want.last)
        report_mismatch("is_last", 32'(res.is_last), 32'(want.last));
      if (want.kind == KIND_FIRED) alarms_seen++;
      else answers_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      period_ms = TICK_PERIOD_RESET;
      tick_count = '0;
      start_mark = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        due_time[i] = DUE_OFF;
        reload_period[i] = '0;
      end
      timer_results_q.delete();
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) check_result();
      if (psel && penable && pready && paddr == ADDR_TICK_PERIOD) begin
        if (pwrite) period_ms = pwdata[7:0];
        else if (prdata !== {24'h0, period_ms})
          report_mismatch("tick period readback", prdata, {24'h0, period_ms});
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        if (req.req_type <= REQ_QUERY) requests_seen++;
        advance_timer(req.req_type, req.channel, req.delay_ticks, req.reload_ticks);
      end
    end
    outstanding = timer_results_q.size();
  end

endmodule

// ===== bench/tb_multi_channel_alarm_timer_unit.sv =====
// testbench top for the multi-channel alarm timer: clock, reset, request and register stimulus
// depends on mcat_pkg, the channel interfaces, the timer RTL and alarm_timer_check
module tb_multi_channel_alarm_timer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mcat_pkg::*;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bit gaps_on;
  bit stalls_on;
  int fail_count;
  int outstanding;
  int requests_seen;
  int alarms_seen;
  int answers_seen;

  mcat_req_if req_ch();
  mcat_res_if res_ch();

  multi_channel_alarm_timer_unit uut (
    .clk(clk), .rst(rst), .req(req_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  alarm_timer_check u_check (
    .clk(clk), .rst(rst), .req(req_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(fail_count), .outstanding(outstanding), .requests_seen(requests_seen),
    .alarms_seen(alarms_seen), .answers_seen(answers_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send_req(logic [2:0] code, logic [1:0] chan, logic [31:0] delay,
                          logic [31:0] reload);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= code;
    req_ch.channel <= chan;
    req_ch.delay_ticks <= delay;
    req_ch.reload_ticks <= reload;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic end_burst();
    req_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_access(logic write, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= ADDR_TICK_PERIOD;
    pwdata <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until the checker expects no further result before the next phase
  task automatic wait_idle();
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(int n);
    int roll;
    logic [2:0] code;
    logic [1:0] chan;
    logic [31:0] delay;
    logic [31:0] reload;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0)
        send_req(3'($urandom_range(6, 7)), 2'($urandom), $urandom, $urandom);
      roll = $urandom_range(0, 99);
      chan = 2'($urandom_range(0, 3));
      delay = $urandom;
      reload = $urandom;
      if (roll < 44) begin
        code = REQ_TICK;
      end else if (roll < 66) begin
        code = REQ_ARM;
        if ($urandom_range(0, 3) != 0) begin
          delay = $urandom_range(0, 8);
          reload = $urandom_range(0, 5);
        end
      end else if (roll < 78) begin
        code = REQ_QUERY;
      end else if (roll < 85) begin
        code = REQ_DISARM;
      end else if (roll < 88) begin
        code = REQ_DISARM_ALL;
      end else begin
        code = REQ_MARK;
      end
      send_req(code, chan, delay, reload);
    end
    end_burst();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.channel = '0;
    req_ch.delay_ticks = '0;
    req_ch.reload_ticks = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apb_access(1'b0, 8'h0);
    apb_access(1'b1, 8'd1);
    apb_access(1'b0, 8'h0);

    // directed: idle channel, wrapped due times, max reload, all four firing at once
    send_req(REQ_QUERY, 2'd0, 32'h0, 32'h0);
    send_req(REQ_TICK, 2'd3, 32'hffff_ffff, 32'hffff_ffff);
    send_req(REQ_ARM, 2'd0, 32'h0, 32'h0);
    send_req(REQ_ARM, 2'd1, 32'hffff_ffff, 32'd2);
    send_req(REQ_ARM, 2'd2, 32'd1, 32'hffff_ffff);
    send_req(REQ_ARM, 2'd3, 32'hffff_fffe, 32'd1);
    send_req(REQ_MARK, 2'd3, 32'h0, 32'h0);
    send_req(REQ_TICK, 2'd0, 32'h0, 32'h0);
    send_req(REQ_TICK, 2'd1, 32'h5555_5555, 32'haaaa_aaaa);
    send_req(REQ_TICK, 2'd2, 32'haaaa_aaaa, 32'h5555_5555);
    send_req(REQ_QUERY, 2'd2, 32'h0, 32'h0);
    send_req(REQ_QUERY, 2'd0, 32'h0, 32'h0);
    send_req(REQ_ARM, 2'd0, 32'hffff_ffff, 32'd0);
    send_req(REQ_ARM, 2'd1, 32'hffff_ffff, 32'd0);
    send_req(REQ_ARM, 2'd2, 32'hffff_ffff, 32'd3);
    send_req(REQ_ARM, 2'd3, 32'hffff_ffff, 32'h8000_0000);
    send_req(REQ_TICK, 2'd0, 32'h0, 32'h0);
    send_req(REQ_DISARM, 2'd2, 32'h0, 32'h0);
    send_req(REQ_QUERY, 2'd3, 32'h0, 32'h0);
    send_req(3'd6, 2'd1, 32'h0, 32'h0);
    send_req(3'd7, 2'd2, 32'hffff_ffff, 32'hffff_ffff);
    send_req(REQ_DISARM_ALL, 2'd2, 32'h0, 32'h0);
    send_req(REQ_TICK, 2'd1, 32'h0, 32'h0);
    send_req(REQ_MARK, 2'd1, 32'h0, 32'h0);
    end_burst();
    wait_idle();

    apb_access(1'b1, 8'd255);
    apb_access(1'b0, 8'h0);
    run_phase(90);
    wait_idle();

    apb_access(1'b1, 8'($urandom_range(2, 254)));
    run_phase(90);
    wait_idle();

    gaps_on = 1'b0;
    stalls_on = 1'b0;
    apb_access(1'b1, TICK_PERIOD_RESET);
    apb_access(1'b0, 8'h0);
    run_phase(80);
    wait_idle();

    $display("covered %0d requests with tick periods 1, 255, random and 16", requests_seen);
    $display("checked %0d fired alarms and %0d acks and answers", alarms_seen, answers_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
